[sv/tofm_pkg.sv]
// Package: widths, register map, payload word types for the touch oscillator frequency meter
`timescale 1ns / 1ps

package tofm_pkg;

    // Field and state widths
    localparam int TICK_W    = 32;               // elapsed tick counter
    localparam int CPS_W     = 8;                // cycles_per_sample
    localparam int AVG_W     = 5;                // samples_to_average
    localparam int HZ_W      = 32;               // clock_hz and frequency
    localparam int SUM_W     = 36;               // sample sum
    localparam int NUM_W     = CPS_W + HZ_W;     // product cycles * clock_hz
    localparam int DIV_STEPS = NUM_W;            // one quotient bit per cycle
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Averaging count limits
    localparam logic [AVG_W-1:0] AVG_MIN = AVG_W'(1);
    localparam logic [AVG_W-1:0] AVG_MAX = AVG_W'(16);

    // Configuration port
    localparam int APB_DW = 32;
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_CYCLES  = 2'd0;
    localparam logic [1:0] REG_SAMPLES = 2'd1;
    localparam logic [1:0] REG_CLK_HZ  = 2'd2;

    // Reset values of the registers
    localparam logic [CPS_W-1:0] CPS_RST    = CPS_W'(20);
    localparam logic [AVG_W-1:0] AVG_RST    = AVG_W'(10);
    localparam logic [HZ_W-1:0]  CLK_HZ_RST = HZ_W'(32000000);

    // Input word: one clock tick
    typedef struct packed {
        logic start_req;
        logic pin_high;
    } tofm_in_t;

    // Result word: one per tick
    typedef struct packed {
        logic            pull_up;
        logic            busy_res;
        logic            result_valid;
        logic [HZ_W-1:0] frequency_hz;
    } tofm_out_t;

endpackage

[sv/touch_oscillator_frequency_meter.sv]
// Top level: relaxation oscillator frequency meter with a shared iterative divider
`timescale 1ns / 1ps

// Channel   | Ports                          | Word
// ----------+--------------------------------+---------------------------------------------
// input     | s_valid, s_ready, s_data       | tofm_in_t: start_req, pin_high
// result    | m_valid, m_ready, m_data       | tofm_out_t: pull_up, busy_res, result_valid,
//           |                                |   frequency_hz
// config    | psel, penable, pwrite, paddr,  | cycles_per_sample @0x0, samples_to_average
//           | pwdata, prdata, pready         |   @0x4, clock_hz @0x8
//
// A tick that does not end a sample has its word loaded into the output register as the
// tick is taken. A tick that ends a sample runs through the taking cycle, one multiply, 40
// restoring divide steps in the shared divider, one sum and one output load; when it also
// ends the average, the mean runs a second 40-step pass through the same divider before
// the output load. A sample with zero elapsed ticks skips its divide pass.
// Synchronous active-low reset returns to idle with the register reset values.
// A stalled result channel holds the output word and stops intake until it drains.

module touch_oscillator_frequency_meter (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tofm_pkg::tofm_in_t            s_data,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output tofm_pkg::tofm_out_t           m_data,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tofm_pkg::ADDR_W-1:0]   paddr,
    input  logic [tofm_pkg::APB_DW-1:0]   pwdata,
    output logic [tofm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    import tofm_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DISCHARGE,
        PH_ALIGN_UP,
        PH_ALIGN_DOWN,
        PH_MEAS_UP,
        PH_MEAS_DOWN
    } phase_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_OUT
    } seq_t;

    // Configuration registers
    logic [CPS_W-1:0]  cps_reg,     cps_next;
    logic [AVG_W-1:0]  avg_reg,     avg_next;
    logic [HZ_W-1:0]   clk_hz_reg,  clk_hz_next;

    // Measurement state
    phase_t            ph_reg,      ph_next;
    logic [CPS_W-1:0]  cyc_reg,     cyc_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic [AVG_W-1:0]  smp_reg,     smp_next;
    logic [SUM_W-1:0]  sum_reg,     sum_next;

    // Sequencer and shared divider
    seq_t              st_reg,      st_next;
    logic              avg_due_reg, avg_due_next;   // this sample closes the average
    logic              avg_pass_reg, avg_pass_next; // divider is working on the mean
    logic [NUM_W-1:0]  num_reg,     num_next;       // dividend, quotient shifts in
    logic [TICK_W-1:0] den_reg,     den_next;
    logic [TICK_W-1:0] rem_reg,     rem_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    tofm_out_t         m_data_reg,  m_data_next;

    // Helpers
    logic              cfg_wr;
    logic              out_free;
    logic              take;
    logic [AVG_W-1:0]  avg_n;
    logic [CPS_W-1:0]  cyc_inc;
    logic [AVG_W-1:0]  smp_inc;
    logic              finish;
    logic [TICK_W:0]   rem_sh;
    logic              div_ge;
    logic [TICK_W:0]   rem_sub;
    logic [HZ_W-1:0]   smp_freq;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (st_reg == ST_RUN) && out_free;
    assign take     = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Register read-back
    always_comb begin
        case (paddr[3:2])
            REG_CYCLES:  prdata = APB_DW'(cps_reg);
            REG_SAMPLES: prdata = APB_DW'(avg_reg);
            REG_CLK_HZ:  prdata = APB_DW'(clk_hz_reg);
            default:     prdata = '0;
        endcase
    end

    // Averaging count clamped to 1..16
    always_comb begin
        if (avg_reg == '0) begin
            avg_n = AVG_MIN;
        end else if (avg_reg > AVG_MAX) begin
            avg_n = AVG_MAX;
        end else begin
            avg_n = avg_reg;
        end
    end

    assign cyc_inc = cyc_reg + CPS_W'(1);
    assign smp_inc = smp_reg + AVG_W'(1);

    // One restoring divide step
    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge  = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    // Sample quotient saturated to 32 bits
    assign smp_freq = (num_reg[NUM_W-1:HZ_W] != '0) ? '1 : num_reg[HZ_W-1:0];

    // Next state
    always_comb begin
        cps_next      = cps_reg;
        avg_next      = avg_reg;
        clk_hz_next   = clk_hz_reg;
        ph_next       = ph_reg;
        cyc_next      = cyc_reg;
        elapsed_next  = elapsed_reg;
        smp_next      = smp_reg;
        sum_next      = sum_reg;
        st_next       = st_reg;
        avg_due_next  = avg_due_reg;
        avg_pass_next = avg_pass_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        finish        = 1'b0;

        // configuration writes
        if (cfg_wr) begin
            case (paddr[3:2])
                REG_CYCLES:  cps_next    = pwdata[CPS_W-1:0];
                REG_SAMPLES: avg_next    = pwdata[AVG_W-1:0];
                REG_CLK_HZ:  clk_hz_next = pwdata[HZ_W-1:0];
                default:     ;
            endcase
        end

        case (st_reg)
            // take one tick and step the oscillator phase
            ST_RUN: begin
                if (take) begin
                    case (ph_reg)
                        PH_IDLE: begin
                            if (s_data.start_req) begin
                                ph_next      = PH_DISCHARGE;
                                smp_next     = '0;
                                sum_next     = '0;
                                cyc_next     = '0;
                                elapsed_next = '0;
                            end
                        end
                        PH_DISCHARGE: begin
                            if (!s_data.pin_high) ph_next = PH_ALIGN_UP;
                        end
                        PH_ALIGN_UP: begin
                            if (s_data.pin_high) ph_next = PH_ALIGN_DOWN;
                        end
                        PH_ALIGN_DOWN: begin
                            if (!s_data.pin_high) begin
                                elapsed_next = '0;
                                cyc_next     = '0;
                                if (cps_reg == '0) begin
                                    finish = 1'b1;
                                end else begin
                                    ph_next = PH_MEAS_UP;
                                end
                            end
                        end
                        PH_MEAS_UP: begin
                            if (elapsed_reg != '1) elapsed_next = elapsed_reg + TICK_W'(1);
                            if (s_data.pin_high) ph_next = PH_MEAS_DOWN;
                        end
                        PH_MEAS_DOWN: begin
                            if (elapsed_reg != '1) elapsed_next = elapsed_reg + TICK_W'(1);
                            if (!s_data.pin_high) begin
                                if (cyc_inc >= cps_reg) begin
                                    finish = 1'b1;
                                end else begin
                                    cyc_next = cyc_inc;
                                    ph_next  = PH_MEAS_UP;
                                end
                            end
                        end
                        default: ph_next = PH_IDLE;
                    endcase

                    if (finish) begin
                        // sample ends: bookkeeping now, arithmetic follows
                        smp_next      = smp_inc;
                        cyc_next      = '0;
                        avg_due_next  = smp_inc >= avg_n;
                        ph_next       = (smp_inc >= avg_n) ? PH_IDLE : PH_DISCHARGE;
                        avg_pass_next = 1'b0;
                        st_next       = ST_MUL;
                    end else begin
                        m_valid_next              = 1'b1;
                        m_data_next.pull_up       = (ph_next == PH_ALIGN_UP) ||
                                                    (ph_next == PH_MEAS_UP);
                        m_data_next.busy_res      = ph_next != PH_IDLE;
                        m_data_next.result_valid  = 1'b0;
                        m_data_next.frequency_hz  = '0;
                    end
                end
            end

            // cycles times clock rate, then divide by elapsed ticks (no divide for zero ticks)
            ST_MUL: begin
                den_next = elapsed_reg;
                rem_next = '0;
                cnt_next = '0;
                if (elapsed_reg == '0) begin
                    num_next = '0;
                    st_next  = ST_SUM;
                end else begin
                    num_next = {{HZ_W{1'b0}}, cps_reg} * {{CPS_W{1'b0}}, clk_hz_reg};
                    st_next  = ST_DIV;
                end
            end

            // shared divider, one quotient bit a cycle
            ST_DIV: begin
                rem_next = div_ge ? rem_sub[TICK_W-1:0] : rem_sh[TICK_W-1:0];
                num_next = {num_reg[NUM_W-2:0], div_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    st_next = avg_pass_reg ? ST_OUT : ST_SUM;
                end
            end

            // add the sample; start the mean if this was the last one
            ST_SUM: begin
                sum_next = sum_reg + SUM_W'(smp_freq);
                if (avg_due_reg) begin
                    num_next      = NUM_W'(sum_reg + SUM_W'(smp_freq));
                    den_next      = TICK_W'(avg_n);
                    rem_next      = '0;
                    cnt_next      = '0;
                    avg_pass_next = 1'b1;
                    st_next       = ST_DIV;
                end else begin
                    st_next = ST_OUT;
                end
            end

            // hand the word of the sample-ending tick to the output register
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.pull_up      = 1'b0;
                    m_data_next.busy_res     = ph_reg != PH_IDLE;
                    m_data_next.result_valid = avg_pass_reg;
                    m_data_next.frequency_hz = avg_pass_reg ? num_reg[HZ_W-1:0] : '0;
                    st_next                  = ST_RUN;
                end
            end

            default: st_next = ST_RUN;
        endcase
    end

    // State and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cps_reg      <= CPS_RST;
            avg_reg      <= AVG_RST;
            clk_hz_reg   <= CLK_HZ_RST;
            ph_reg       <= PH_IDLE;
            cyc_reg      <= '0;
            elapsed_reg  <= '0;
            smp_reg      <= '0;
            sum_reg      <= '0;
            st_reg       <= ST_RUN;
            avg_due_reg  <= 1'b0;
            avg_pass_reg <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            cps_reg      <= cps_next;
            avg_reg      <= avg_next;
            clk_hz_reg   <= clk_hz_next;
            ph_reg       <= ph_next;
            cyc_reg      <= cyc_next;
            elapsed_reg  <= elapsed_next;
            smp_reg      <= smp_next;
            sum_reg      <= sum_next;
            st_reg       <= st_next;
            avg_due_reg  <= avg_due_next;
            avg_pass_reg <= avg_pass_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        m_data_reg <= m_data_next;
    end

    // Checks
    a_avg_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.result_valid) |-> !m_data.busy_res)
        else $error("average delivered while still busy");

    a_freq_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.result_valid) |-> (m_data.frequency_hz == '0))
        else $error("frequency without result_valid");

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && ph_reg == PH_IDLE && s_data.start_req) |=> (ph_reg == PH_DISCHARGE))
        else $error("start did not enter discharge");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_DIV) |-> (cnt_reg < CNT_W'(DIV_STEPS)))
        else $error("divider step count out of range");

    a_busy_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != ST_RUN) |-> !s_ready)
        else $error("tick taken while the divider is working");

endmodule
